// File: src/range_histogram_tally_core_assert.svh
// Assertion macros for the range histogram tally block.
// Used by the checker module; expects clk_i and rst_ni in the enclosing scope.
`ifndef RANGE_HISTOGRAM_TALLY_CORE_ASSERT_SVH
`define RANGE_HISTOGRAM_TALLY_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("range histogram tally: assertion failed");

// Next-cycle implication, checked out of reset.
`define RHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("range histogram tally: assertion failed");

`endif

// File: src/rht_pkg.sv
// Package for the range histogram tally block: sizes, codes and payload types.
// No dependencies; imported by range_histogram_tally_core and the checker.
`default_nettype none

package rht_pkg;

  localparam int MAX_BINS = 1024;
  localparam int BinAw    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NbW      = $clog2(MAX_BINS + 1);

  localparam int CntW     = 32;
  localparam int CfgW     = 24;
  localparam int CfgAw    = 2;
  localparam int DivW     = 33;   // nonnegative dividend width
  localparam int DvW      = 24;   // divisor width
  localparam int StepW    = $clog2(DivW);

  localparam logic [1:0] REQ_RECORD = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [CfgAw-1:0] CFG_RANGE_MIN   = 2'd0;
  localparam logic [CfgAw-1:0] CFG_RANGE_MAX   = 2'd1;
  localparam logic [CfgAw-1:0] CFG_CLUMP_SIZE  = 2'd2;
  localparam logic [CfgAw-1:0] CFG_BINS_IN_USE = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] low_value;
    logic signed [31:0] high_value;
    logic [9:0]         bin_index;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] bin_value;
    logic [31:0] samples_seen;
  } rsp_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    return (c == '1) ? c : c + CntW'(1);
  endfunction

endpackage

`default_nettype wire

// File: src/rht_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module rht_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/range_histogram_tally_core.sv
// Range histogram tally: interval binning into a RAM of saturating counters.
// Depends on rht_pkg and rht_ram.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  request  | in_valid_i/in_stall_o | in_data_i  (rht_pkg::req_t)
//  result   | out_valid_o/out_stall_i | out_data_o (rht_pkg::rsp_t)
//  config   | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One request at a time. Record: setup, 33 divide steps (both bin
// divisions run side by side, one quotient bit per cycle), evaluate, a RAM
// read-modify-write per bin from a to b, a last write-back and the result.
// Read: registered RAM read, then the result. Clear: a MAX_BINS sweep, then
// the result. After reset the counter RAM, all MAX_BINS (1024) entries, is
// swept to zero with in_stall_o high. The result register lets a new
// request in while the previous result waits; one finishing meanwhile holds.
`default_nettype none

module range_histogram_tally_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire rht_pkg::req_t             in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output rht_pkg::rsp_t                  out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [rht_pkg::CfgAw-1:0] cfg_idx_i,
  input  wire logic [rht_pkg::CfgW-1:0]  cfg_data_i
);

  import rht_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_DIV, ST_EVAL, ST_WALK, ST_WLAST, ST_RDATA, ST_DONE
  } state_e;

  typedef struct packed {
    logic [DivW-1:0] num;
    logic [DvW-1:0]  rem;
  } div_t;

  // configuration
  logic signed [23:0] cfg_min_q, cfg_max_q;
  logic [23:0]        cfg_clump_q;
  logic [10:0]        cfg_bins_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_min_q   <= 24'sd0;
      cfg_max_q   <= 24'sd1;
      cfg_clump_q <= 24'd256;
      cfg_bins_q  <= 11'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE_MIN:   cfg_min_q   <= cfg_data_i[23:0];
        CFG_RANGE_MAX:   cfg_max_q   <= cfg_data_i[23:0];
        CFG_CLUMP_SIZE:  cfg_clump_q <= cfg_data_i[23:0];
        CFG_BINS_IN_USE: cfg_bins_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  state_e            state_q;
  logic [BinAw-1:0]  clr_idx_q;
  logic              clr_rsp_q;
  req_t              req_q;
  logic [DivW-1:0]   num_a_q, num_b_q;
  logic [DvW-1:0]    rem_a_q, rem_b_q;
  logic [StepW-1:0]  step_q;
  logic              b_top_q, b_neg_q;
  logic [BinAw-1:0]  cur_q, end_q, prev_q;
  logic              rd_pend_q;
  logic              idx_ok_q;
  logic              pend_status_q;
  logic [CntW-1:0]   pend_value_q;
  logic [CntW-1:0]   sample_q;
  logic              out_valid_q;
  rsp_t              out_q;

  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  // result register loads when empty or drained this cycle
  logic out_load;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // operand setup
  logic [DvW-1:0]     dv;
  logic signed [24:0] mx_int;
  logic signed [33:0] mn_s, mx_s, low_s, high_s, num_a_s, num_b_s;
  logic [NbW-1:0]     nb_eff;

  always_comb begin
    dv     = (cfg_clump_q == '0) ? DvW'(1) : cfg_clump_q;
    mx_int = (cfg_max_q <= cfg_min_q) ? (25'(cfg_min_q) + 25'sd1) : 25'(cfg_max_q);
    mn_s   = {{2{cfg_min_q[23]}}, cfg_min_q, 8'h00};
    mx_s   = {mx_int[24], mx_int, 8'h00};
    low_s  = 34'(req_q.low_value);
    high_s = 34'(req_q.high_value);
    num_a_s = low_s - mn_s;
    num_b_s = high_s - mn_s;
    if (cfg_bins_q == '0) begin
      nb_eff = NbW'(1);
    end else if (32'(cfg_bins_q) > 32'(MAX_BINS)) begin
      nb_eff = NbW'(MAX_BINS);
    end else begin
      nb_eff = NbW'(cfg_bins_q);
    end
  end

  // one restoring step per cycle; quotient bits shift into num
  function automatic div_t div_step(input logic [DivW-1:0] num, input logic [DvW-1:0] rem,
                                    input logic [DvW-1:0] d);
    logic [DvW:0] t;
    logic         ge;
    div_t         r;
    t     = {rem, num[DivW-1]};
    ge    = (t >= {1'b0, d});
    r.rem = ge ? DvW'(t - {1'b0, d}) : t[DvW-1:0];
    r.num = {num[DivW-2:0], ge};
    return r;
  endfunction

  div_t nxt_a, nxt_b;
  assign nxt_a = div_step(num_a_q, rem_a_q, dv);
  assign nxt_b = div_step(num_b_q, rem_b_q, dv);

  // evaluation of the two bin indexes
  logic [DivW-1:0] b_val;
  logic            rec_err, rec_empty;
  always_comb begin
    b_val     = b_top_q ? DivW'(nb_eff - NbW'(1)) : num_b_q;
    rec_err   = !b_top_q && !b_neg_q && (num_b_q >= DivW'(nb_eff));
    rec_empty = (b_neg_q && !b_top_q) || (num_a_q > b_val);
  end

  // counter RAM
  logic             ram_we, ram_re;
  logic [BinAw-1:0] ram_waddr, ram_raddr;
  logic [CntW-1:0]  ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = prev_q;
    ram_wdata = sat_inc(ram_rdata);
    ram_re    = 1'b0;
    ram_raddr = cur_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_re    = in_acc && (in_data_i.req_type == REQ_READ);
        ram_raddr = BinAw'(in_data_i.bin_index);
      end
      ST_WALK: begin
        ram_we = rd_pend_q;
        ram_re = 1'b1;
      end
      ST_WLAST: ram_we = rd_pend_q;
      default: ;
    endcase
  end

  rht_ram #(
    .Width(CntW),
    .Depth(MAX_BINS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      clr_rsp_q   <= 1'b0;
      step_q      <= '0;
      rd_pend_q   <= 1'b0;
      sample_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          sample_q  <= '0;
          clr_idx_q <= clr_idx_q + BinAw'(1);
          if (clr_idx_q == BinAw'(MAX_BINS - 1)) begin
            state_q <= clr_rsp_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            req_q         <= in_data_i;
            pend_status_q <= 1'b0;
            pend_value_q  <= '0;
            idx_ok_q      <= (32'(in_data_i.bin_index) < 32'(MAX_BINS));
            case (in_data_i.req_type)
              REQ_RECORD: state_q <= ST_SETUP;
              REQ_READ:   state_q <= ST_RDATA;
              REQ_CLEAR: begin
                clr_idx_q <= '0;
                clr_rsp_q <= 1'b1;
                state_q   <= ST_CLEAR;
              end
              default:    state_q <= ST_DONE;
            endcase
          end
        end
        ST_SETUP: begin
          // start bin is zero at or below the minimum
          num_a_q <= (low_s <= mn_s) ? '0 : num_a_s[DivW-1:0];
          num_b_q <= num_b_s[DivW-1:0];
          rem_a_q <= '0;
          rem_b_q <= '0;
          b_top_q <= (high_s >= mx_s);
          b_neg_q <= num_b_s[33];
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          num_a_q <= nxt_a.num;
          rem_a_q <= nxt_a.rem;
          num_b_q <= nxt_b.num;
          rem_b_q <= nxt_b.rem;
          step_q  <= step_q + StepW'(1);
          if (step_q == StepW'(DivW - 1)) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (rec_err) begin
            pend_status_q <= 1'b1;
            state_q       <= ST_DONE;
          end else begin
            sample_q <= sat_inc(sample_q);
            if (rec_empty) begin
              state_q <= ST_DONE;
            end else begin
              cur_q     <= BinAw'(num_a_q);
              end_q     <= BinAw'(b_val);
              rd_pend_q <= 1'b0;
              state_q   <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          // read cur while the previous bin is written back
          prev_q    <= cur_q;
          rd_pend_q <= 1'b1;
          if (cur_q == end_q) begin
            state_q <= ST_WLAST;
          end else begin
            cur_q <= cur_q + BinAw'(1);
          end
        end
        ST_WLAST: begin
          rd_pend_q <= 1'b0;
          state_q   <= ST_DONE;
        end
        ST_RDATA: begin
          pend_value_q <= idx_ok_q ? ram_rdata : '0;
          state_q      <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_q.status       <= pend_status_q;
            out_q.bin_value    <= pend_value_q;
            out_q.samples_seen <= sample_q;
            clr_rsp_q          <= 1'b0;
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: src/rht_checker.sv
// Port-level checker for range_histogram_tally_core, bound to the top level.
// Depends on rht_pkg and range_histogram_tally_core_assert.svh.
`default_nettype none

`include "range_histogram_tally_core_assert.svh"

module rht_port_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire rht_pkg::req_t in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire rht_pkg::rsp_t out_data_o
);

  import rht_pkg::*;

  // stalled result transaction holds
  `RHT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // requests are processed one at a time
  `RHT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // the counter sweep after reset blocks requests
  `RHT_ASSERT_NOW(a_sweep_after_reset, !$past(rst_ni), in_stall_o)

  // a new result appears only at the end of a busy period
  `RHT_ASSERT_NOW(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o))

  // an error result records nothing and returns no bin count
  `RHT_ASSERT_NOW(a_err_no_value, out_valid_o && out_data_o.status, out_data_o.bin_value == '0)

endmodule

bind range_histogram_tally_core rht_port_checker u_rht_checker (.*);

`default_nettype wire
